### sv/integer_to_ascii_radix_assert.svh
// Assertion helpers for the integer to ASCII converter.
// Every check samples on the rising edge of aclk and is idle during reset.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// A condition that must hold at every clock edge.
`define ITOA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that must hold whenever a trigger is seen at the same edge.
`define ITOA_ASSERT_IMPLY(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error(msg);

`endif

### sv/itoa_pkg.sv
// ---------------------------------------------------------------------------
// itoa_pkg
// Shared constants, sequencer states and the digit-to-character mapping of
// the integer to ASCII converter.
// ---------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int IN_W           = 32;
    localparam int RADIX_W        = 6;
    localparam int CHAR_W         = 8;

    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } itoa_state_t;

    // Digit values below ten map to '0'..'9', the rest to 'a'..'z'.
    function automatic logic [CHAR_W-1:0] itoa_digit_char(input logic [RADIX_W-1:0] dig);
        logic [CHAR_W-1:0] dig_w;
        dig_w = {{(CHAR_W-RADIX_W){1'b0}}, dig};
        if (dig < RADIX_DEC) begin
            return CHAR_ZERO + dig_w;
        end else begin
            return CHAR_A + dig_w - {{(CHAR_W-RADIX_W){1'b0}}, RADIX_DEC};
        end
    endfunction

endpackage

### sv/itoa_ram.sv
// ---------------------------------------------------------------------------
// itoa_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/itoa_div.sv
// ---------------------------------------------------------------------------
// itoa_div
// Restoring divider that produces one quotient bit per cycle. It divides an
// unsigned value by a small radix and returns quotient and remainder.
// ---------------------------------------------------------------------------
module itoa_div #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [VALUE_BITS-1:0]        dividend,
    input  logic [itoa_pkg::RADIX_W-1:0] divisor,
    output logic                         done,
    output logic [VALUE_BITS-1:0]        quotient,
    output logic [itoa_pkg::RADIX_W-1:0] remainder
);
    import itoa_pkg::*;

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS-1:0] quo_reg,  quo_next;
    logic [RADIX_W-1:0]    rem_reg,  rem_next;
    logic [RADIX_W-1:0]    div_reg,  div_next;
    logic [RADIX_W:0]      trial;
    logic [RADIX_W:0]      diff;

    // One step: bring in the next dividend bit and subtract if it fits.
    always_comb begin
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        diff      = trial - {1'b0, div_reg};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            cnt_next = CNT_W'(VALUE_BITS);
            quo_next = dividend;
            rem_next = '0;
            div_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[RADIX_W-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[RADIX_W-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

### sv/integer_to_ascii_radix.sv
// Sequence: a nonzero value is divided by the radix once per digit, each
//   round done by the bit-serial divider, then a minus sign is stored when
//   there is one, then each character is read, loaded and sent.
// Zero and a bad radix give their single word on the cycle after acceptance.
// Throughput: one number at a time; the input is not ready until the last word
//   of the previous number has been taken.
// Reset: synchronous, active low; clears the sequencer and counters only.
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts an integer, signed in radix 10 and unsigned in any other, into
// ASCII digits in a radix from 2 to 36, sent most significant first, one word per character.
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_assert.svh"

module integer_to_ascii_radix #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [itoa_pkg::IN_W-1:0]    s_value,
    input  logic        [itoa_pkg::RADIX_W-1:0] s_radix,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [itoa_pkg::CHAR_W-1:0]  m_char_code,
    output logic                                m_last,
    output logic                                m_bad_radix
);
    import itoa_pkg::*;

    // The digit buffer holds all digits plus a possible minus sign.
    localparam int DEPTH  = VALUE_BITS + 1;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    itoa_state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg,  cnt_next;
    logic               neg_reg,  neg_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               bad_reg,  bad_next;
    logic [RADIX_W-1:0] radix_reg, radix_next;

    // Input decode. The value is sign extended or truncated to VALUE_BITS.
    logic [VALUE_BITS-1:0] v_in;
    logic [VALUE_BITS-1:0] v_mag;
    logic                  in_bad;
    logic                  in_zero;
    logic                  in_neg;
    logic                  accept;

    // Divider and digit buffer connections.
    logic                  div_start;
    logic [VALUE_BITS-1:0] div_dividend;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_quotient;
    logic [RADIX_W-1:0]    div_rem;
    logic                  quo_zero;
    logic                  ram_we;
    logic [CHAR_W-1:0]     ram_wdata;
    logic [CHAR_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]      cnt_dec;

    always_comb begin
        v_in    = VALUE_BITS'(s_value);
        in_bad  = (s_radix < RADIX_MIN) || (s_radix > RADIX_MAX);
        in_zero = (v_in == '0);
        in_neg  = (s_radix == RADIX_DEC) && v_in[VALUE_BITS-1];
        // Two's complement negate; the most negative value maps onto itself,
        // which read unsigned is exactly its magnitude.
        v_mag   = in_neg ? (~v_in + 1'b1) : v_in;
        accept  = s_valid && s_ready;
    end

    assign quo_zero = (div_quotient == '0);
    assign cnt_dec  = cnt_reg - 1'b1;

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (in_bad || in_zero) ? ST_SEND : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (!quo_zero) begin
                        state_next = ST_DIV;
                    end else if (neg_reg) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_SIGN: state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SEND;
            ST_SEND: begin
                if (m_ready) begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and datapath strobes decoded from the state.
    always_comb begin
        s_ready      = 1'b0;
        m_valid      = 1'b0;
        div_start    = 1'b0;
        div_dividend = v_mag;
        ram_we       = 1'b0;
        ram_wdata    = itoa_digit_char(div_rem);
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid && !in_bad && !in_zero;
            end
            ST_DIV: begin
                // Each finished digit is stored; the quotient feeds the next round.
                ram_we       = div_done;
                div_start    = div_done && !quo_zero;
                div_dividend = div_quotient;
            end
            ST_SIGN: begin
                ram_we    = 1'b1;
                ram_wdata = CHAR_MINUS;
            end
            ST_SEND: m_valid = 1'b1;
            default: ;
        endcase
    end

    // Register updates. Digits are stored least significant first and read
    // back from the top of the buffer down, which reverses their order.
    always_comb begin
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        bad_next   = bad_reg;
        radix_next = radix_reg;
        if (accept) begin
            cnt_next   = '0;
            neg_next   = in_neg;
            char_next  = in_bad ? CHAR_NONE : CHAR_ZERO;
            last_next  = 1'b1;
            bad_next   = in_bad;
            radix_next = s_radix;
        end
        if (ram_we) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (state_reg == ST_LOAD) begin
            char_next = ram_rdata;
            last_next = (cnt_reg == CNT_W'(1));
            bad_next  = 1'b0;
            cnt_next  = cnt_dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
        neg_reg   <= neg_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
        bad_reg   <= bad_next;
        radix_reg <= radix_next;
    end

    itoa_div #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (accept ? s_radix : radix_reg),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_rem)
    );

    itoa_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[ADDR_W-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (cnt_dec[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign m_char_code = char_reg;
    assign m_last      = last_reg;
    assign m_bad_radix = bad_reg;

    // The converter works on one number at a time.
    `ITOA_ASSERT_ALWAYS(a_one_side, !(s_ready && m_valid), "input ready while a word is pending")
    // An error word is the only word of its number and carries no character.
    `ITOA_ASSERT_IMPLY(a_bad_word, m_valid && m_bad_radix, m_last && (m_char_code == CHAR_NONE), "malformed error word")
    // The digit buffer never overflows.
    `ITOA_ASSERT_ALWAYS(a_buf_fill, cnt_reg <= CNT_W'(DEPTH), "digit buffer overflow")
    // The divider only finishes while the sequencer waits for it.
    `ITOA_ASSERT_IMPLY(a_div_owner, div_done, state_reg == ST_DIV, "divider finished outside the division phase")

endmodule
